### hdl/ethertype_port_demux_table_defines.svh
// Assertion macros shared by the demux table RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ETHERTYPE_PORT_DEMUX_TABLE_DEFINES_SVH
`define ETHERTYPE_PORT_DEMUX_TABLE_DEFINES_SVH

// check prop on every clock edge outside reset
`define EDPT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check cons in the cycle after trig
`define EDPT_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

### hdl/edpt_pkg.sv
// Types, codes and constants of the ethertype port demux table.
// No dependencies; used by edpt_cell and ethertype_port_demux_table.
package edpt_pkg;

  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned RealDevices     = 16;

  localparam int unsigned PortW = 10;
  localparam int unsigned DevW  = 4;
  localparam int unsigned LenW  = 16;
  localparam int unsigned CntW  = 64;

  localparam logic [15:0] PortTypeMark  = 16'hAC00;
  localparam logic [15:0] PortFieldMask = 16'h53FF;

  typedef enum logic [1:0] {
    FUNC_FRAME  = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    VERDICT_NORMAL    = 2'd0,
    VERDICT_DELIVERED = 2'd1,
    VERDICT_CONSUMED  = 2'd2,
    VERDICT_DROPPED   = 2'd3
  } verdict_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DUP      = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_FRAME  = 3'd0,
    OP_SCAN   = 3'd1,
    OP_COMMIT = 3'd2,
    OP_REMOVE = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  localparam logic [0:0] RegHookMask = 1'b0;

  typedef struct packed {
    logic             vld;
    op_e              op;
    logic [PortW-1:0] key;
    logic             key_ok;
    logic [DevW-1:0]  dev;
    logic [LenW-1:0]  len;
    logic             hit;
    logic             free;
    logic             claim;
    logic [CntW-1:0]  pkts;
    logic [CntW-1:0]  bytes;
  } token_t;

endpackage

### hdl/edpt_cell.sv
// One table slot of the demux chain: port, device and receive counters.
// Acts on the passing word and hands it to the next cell. Uses edpt_pkg.
module edpt_cell import edpt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  token_t tok_i,
  output token_t tok_o
);

  logic             valid_q, valid_d;
  logic [PortW-1:0] port_q, port_d;
  logic [DevW-1:0]  dev_q, dev_d;
  logic [CntW-1:0]  pkts_q, pkts_d;
  logic [CntW-1:0]  bytes_q, bytes_d;
  token_t           tok_q, tok_d;
  logic             match;

  assign match = valid_q && tok_i.key_ok && (port_q == tok_i.key);

  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    port_d  = port_q;
    dev_d   = dev_q;
    pkts_d  = pkts_q;
    bytes_d = bytes_q;
    if (tok_i.vld) begin
      unique case (tok_i.op)
        OP_FRAME: begin
          if (match && (dev_q == tok_i.dev)) begin
            pkts_d    = pkts_q + CntW'(1);
            bytes_d   = bytes_q + CntW'(tok_i.len);
            tok_d.hit = 1'b1;
          end
        end
        OP_SCAN: begin
          if (match) tok_d.hit = 1'b1;
          if (!valid_q) tok_d.free = 1'b1;
        end
        OP_COMMIT: begin
          if (!valid_q && tok_i.claim) begin
            valid_d     = 1'b1;
            port_d      = tok_i.key;
            dev_d       = tok_i.dev;
            pkts_d      = '0;
            bytes_d     = '0;
            tok_d.claim = 1'b0;
          end
        end
        OP_REMOVE: begin
          if (match) begin
            valid_d   = 1'b0;
            tok_d.hit = 1'b1;
          end
        end
        OP_READ: begin
          if (match) begin
            tok_d.hit   = 1'b1;
            tok_d.pkts  = pkts_q;
            tok_d.bytes = bytes_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    port_q  <= port_d;
    dev_q   <= dev_d;
    pkts_q  <= pkts_d;
    bytes_q <= bytes_d;
  end

  assign tok_o = tok_q;

endmodule

### hdl/ethertype_port_demux_table.sv
// Ingress frame demultiplexer with a chained table of virtual ports.
// Depends on edpt_pkg, edpt_cell and ethertype_port_demux_table_defines.svh.
//
// Usage: drive the item fields with start high; the item is taken at an
// edge where busy is low. Exactly one result word follows, shown for one
// cycle with done_o high; the receiver has no way to stall it.
// The table is a row of TableEntries cells; a command word walks the row
// one cell per cycle. Frames settled by hook, device, loopback, MAC or
// ethertype checks are answered without entering the row. Frame lookup,
// remove, read and an add refused as duplicate or full pass the row once;
// an add that succeeds makes a scan pass, then a write pass.
// busy drops with done_o, so the next item may start in the done_o cycle.
// hook_mask sits at APB address 0; write it only while no word is in flight.
// Reset clears all slots, hook_mask and any word in flight.
`include "ethertype_port_demux_table_defines.svh"

module ethertype_port_demux_table import edpt_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [3:0]  device_id_i,
  input  logic        device_up_i,
  input  logic        is_loopback_i,
  input  logic [47:0] src_mac_i,
  input  logic [15:0] ethertype_i,
  input  logic [15:0] frame_len_i,
  input  logic [15:0] entry_port_i,
  input  logic [3:0]  entry_device_i,
  output logic        done_o,
  output logic [1:0]  verdict_o,
  output logic [1:0]  status_o,
  output logic [9:0]  hit_port_o,
  output logic [63:0] packet_count_o,
  output logic [63:0] byte_count_o
);

  typedef enum logic {S_IDLE, S_WAIT} state_e;

  state_e          state_q;
  logic [15:0]     hook_mask_q;
  token_t          inj_q;
  token_t          tok_w [TableEntries+1];
  token_t          tail;
  token_t          launch_tok;
  token_t          commit_tok;
  logic            launch;
  verdict_e        early_verdict;
  verdict_e        res_verdict;
  status_e         res_status;
  logic            done_q;
  verdict_e        verdict_q;
  status_e         status_q;
  logic [9:0]      hit_port_q;
  logic [63:0]     packet_count_q;
  logic [63:0]     byte_count_q;
  logic            hooked;
  logic            mac_bad;
  logic [15:0]     frame_port;
  logic            cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegHookMask);
  assign prdata = (paddr[2] == RegHookMask) ? {16'b0, hook_mask_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hook_mask_q <= '0;
    end else if (cfg_wr) begin
      hook_mask_q <= pwdata[15:0];
    end
  end

  // front classification
  assign hooked     = ({1'b0, device_id_i} < 5'(RealDevices)) && hook_mask_q[device_id_i];
  assign mac_bad    = src_mac_i[40] || (src_mac_i == 48'b0);
  assign frame_port = ethertype_i & PortFieldMask;

  always_comb begin
    launch        = 1'b1;
    early_verdict = VERDICT_NORMAL;
    launch_tok    = '0;
    launch_tok.vld = 1'b1;
    launch_tok.dev = entry_device_i;
    launch_tok.len = frame_len_i;
    unique case (func_e'(func_i))
      FUNC_FRAME: begin
        launch_tok.op     = OP_FRAME;
        launch_tok.key    = frame_port[PortW-1:0];
        launch_tok.key_ok = (frame_port[15:PortW] == '0);
        launch_tok.dev    = device_id_i;
        priority if (!hooked) begin
          launch = 1'b0;
          early_verdict = VERDICT_NORMAL;
        end else if (!device_up_i) begin
          launch = 1'b0;
          early_verdict = VERDICT_DROPPED;
        end else if (is_loopback_i) begin
          launch = 1'b0;
          early_verdict = VERDICT_NORMAL;
        end else if (mac_bad) begin
          launch = 1'b0;
          early_verdict = VERDICT_DROPPED;
        end else if ((ethertype_i & PortTypeMark) != PortTypeMark) begin
          launch = 1'b0;
          early_verdict = VERDICT_NORMAL;
        end else begin
          launch = 1'b1;
        end
      end
      FUNC_ADD: begin
        launch_tok.op     = OP_SCAN;
        launch_tok.key    = entry_port_i[PortW-1:0];
        launch_tok.key_ok = 1'b1;
      end
      FUNC_REMOVE: begin
        launch_tok.op     = OP_REMOVE;
        launch_tok.key    = entry_port_i[PortW-1:0];
        launch_tok.key_ok = (entry_port_i[15:PortW] == '0);
      end
      FUNC_READ: begin
        launch_tok.op     = OP_READ;
        launch_tok.key    = entry_port_i[PortW-1:0];
        launch_tok.key_ok = (entry_port_i[15:PortW] == '0);
      end
      default: ;
    endcase
  end

  // cell row
  assign tok_w[0] = inj_q;

  for (genvar gi = 0; gi < TableEntries; gi++) begin : g_cell
    edpt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok_w[gi]),
      .tok_o  (tok_w[gi+1])
    );
  end

  assign tail = tok_w[TableEntries];

  always_comb begin
    commit_tok       = tail;
    commit_tok.vld   = 1'b1;
    commit_tok.op    = OP_COMMIT;
    commit_tok.claim = 1'b1;
    res_verdict      = VERDICT_NORMAL;
    res_status       = STATUS_OK;
    unique case (tail.op)
      OP_FRAME:  res_verdict = tail.hit ? VERDICT_DELIVERED : VERDICT_CONSUMED;
      OP_SCAN:   res_status  = tail.hit ? STATUS_DUP : STATUS_FULL;
      OP_COMMIT: res_status  = STATUS_OK;
      OP_REMOVE: res_status  = tail.hit ? STATUS_OK : STATUS_NOTFOUND;
      OP_READ:   res_status  = tail.hit ? STATUS_OK : STATUS_NOTFOUND;
      default: ;
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      inj_q          <= '0;
      done_q         <= 1'b0;
      verdict_q      <= VERDICT_NORMAL;
      status_q       <= STATUS_OK;
      hit_port_q     <= '0;
      packet_count_q <= '0;
      byte_count_q   <= '0;
    end else begin
      done_q    <= 1'b0;
      inj_q.vld <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            if (launch) begin
              inj_q   <= launch_tok;
              state_q <= S_WAIT;
            end else begin
              done_q         <= 1'b1;
              verdict_q      <= early_verdict;
              status_q       <= STATUS_OK;
              hit_port_q     <= '0;
              packet_count_q <= '0;
              byte_count_q   <= '0;
            end
          end
        end
        S_WAIT: begin
          if (tail.vld) begin
            if ((tail.op == OP_SCAN) && !tail.hit && tail.free) begin
              inj_q <= commit_tok;
            end else begin
              state_q        <= S_IDLE;
              done_q         <= 1'b1;
              verdict_q      <= res_verdict;
              status_q       <= res_status;
              hit_port_q     <= (tail.op == OP_FRAME && tail.hit) ? tail.key : '0;
              packet_count_q <= (tail.op == OP_READ && tail.hit) ? tail.pkts : '0;
              byte_count_q   <= (tail.op == OP_READ && tail.hit) ? tail.bytes : '0;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign verdict_o      = verdict_q;
  assign status_o       = status_q;
  assign hit_port_o     = hit_port_q;
  assign packet_count_o = packet_count_q;
  assign byte_count_o   = byte_count_q;

  `EDPT_ASSERT(a_done_in_idle, !done_q || (state_q == S_IDLE), "result while sequencer busy")
  `EDPT_ASSERT(a_inject_in_wait, !inj_q.vld || (state_q == S_WAIT), "word injected while idle")
  `EDPT_ASSERT(a_tail_in_wait, !tail.vld || (state_q == S_WAIT), "word left row while idle")
  `EDPT_ASSERT(a_hit_port_delivered,
    !done_q || (verdict_q == VERDICT_DELIVERED) || (hit_port_q == '0), "stray hit port")
  `EDPT_ASSERT_NEXT(a_accept_progress, start && !busy, done_q || (state_q == S_WAIT),
    "accepted item neither answered nor launched")

endmodule

### tb/tb_ethertype_port_demux_table.sv
`timescale 1ns / 1ps
// Self-checking testbench for ethertype_port_demux_table: directed and random command
// words, with expected verdicts, statuses and counters computed by an in-bench port table.
// Depends on edpt_pkg and the RTL of the block only.
module tb_ethertype_port_demux_table;
  import edpt_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam logic [2:0]  HookMaskAddr = {RegHookMask, 2'b00};

  typedef struct packed {
    func_e       func;
    logic [3:0]  device_id;
    logic        device_up;
    logic        is_loopback;
    logic [47:0] src_mac;
    logic [15:0] ethertype;
    logic [15:0] frame_len;
    logic [15:0] entry_port;
    logic [3:0]  entry_device;
  } word_t;

  typedef struct packed {
    verdict_e    verdict;
    status_e     status;
    logic [9:0]  hit_port;
    logic [63:0] pkts;
    logic [63:0] bytes;
  } outcome_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic [1:0]  func_i;
  logic [3:0]  device_id_i;
  logic        device_up_i;
  logic        is_loopback_i;
  logic [47:0] src_mac_i;
  logic [15:0] ethertype_i;
  logic [15:0] frame_len_i;
  logic [15:0] entry_port_i;
  logic [3:0]  entry_device_i;
  logic        done_o;
  logic [1:0]  verdict_o;
  logic [1:0]  status_o;
  logic [9:0]  hit_port_o;
  logic [63:0] packet_count_o;
  logic [63:0] byte_count_o;

  logic [15:0] hook_mask_q;
  logic        slot_valid_q [TableEntriesDef];
  logic [9:0]  slot_port_q  [TableEntriesDef];
  logic [3:0]  slot_dev_q   [TableEntriesDef];
  logic [63:0] slot_pkts_q  [TableEntriesDef];
  logic [63:0] slot_bytes_q [TableEntriesDef];

  outcome_t pending_outcomes [$];
  int       errors;
  int       idle_pct;
  int       quiet_cycles;

  ethertype_port_demux_table u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .device_id_i    (device_id_i),
    .device_up_i    (device_up_i),
    .is_loopback_i  (is_loopback_i),
    .src_mac_i      (src_mac_i),
    .ethertype_i    (ethertype_i),
    .frame_len_i    (frame_len_i),
    .entry_port_i   (entry_port_i),
    .entry_device_i (entry_device_i),
    .done_o         (done_o),
    .verdict_o      (verdict_o),
    .status_o       (status_o),
    .hit_port_o     (hit_port_o),
    .packet_count_o (packet_count_o),
    .byte_count_o   (byte_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic outcome_t resolve_word(input word_t w);
    outcome_t    r;
    logic [15:0] port;
    int          hit_slot;
    int          free_slot;
    int          i;
    r = '0;
    hit_slot = -1;
    free_slot = -1;
    case (w.func)
      FUNC_FRAME: begin
        if (!hook_mask_q[w.device_id]) r.verdict = VERDICT_NORMAL;
        else if (!w.device_up) r.verdict = VERDICT_DROPPED;
        else if (w.is_loopback) r.verdict = VERDICT_NORMAL;
        else if (w.src_mac[40] || w.src_mac == '0) r.verdict = VERDICT_DROPPED;
        else if ((w.ethertype & PortTypeMark) != PortTypeMark) r.verdict = VERDICT_NORMAL;
        else begin
          port = w.ethertype & PortFieldMask;
          for (i = 0; i < TableEntriesDef; i++) begin
            if (hit_slot < 0 && slot_valid_q[i] && {6'b0, slot_port_q[i]} == port &&
                slot_dev_q[i] == w.device_id) hit_slot = i;
          end
          if (hit_slot >= 0) begin
            slot_pkts_q[hit_slot]  = slot_pkts_q[hit_slot] + 64'd1;
            slot_bytes_q[hit_slot] = slot_bytes_q[hit_slot] + {48'b0, w.frame_len};
            r.verdict  = VERDICT_DELIVERED;
            r.hit_port = port[9:0];
          end else begin
            r.verdict = VERDICT_CONSUMED;
          end
        end
      end
      FUNC_ADD: begin
        for (i = 0; i < TableEntriesDef; i++) begin
          if (slot_valid_q[i] && slot_port_q[i] == w.entry_port[9:0]) hit_slot = i;
          if (!slot_valid_q[i] && free_slot < 0) free_slot = i;
        end
        if (hit_slot >= 0) r.status = STATUS_DUP;
        else if (free_slot < 0) r.status = STATUS_FULL;
        else begin
          slot_valid_q[free_slot] = 1'b1;
          slot_port_q[free_slot]  = w.entry_port[9:0];
          slot_dev_q[free_slot]   = w.entry_device;
          slot_pkts_q[free_slot]  = '0;
          slot_bytes_q[free_slot] = '0;
        end
      end
      default: begin
        for (i = 0; i < TableEntriesDef; i++) begin
          if (slot_valid_q[i] && {6'b0, slot_port_q[i]} == w.entry_port) hit_slot = i;
        end
        if (hit_slot < 0) r.status = STATUS_NOTFOUND;
        else if (w.func == FUNC_REMOVE) slot_valid_q[hit_slot] = 1'b0;
        else begin
          r.pkts  = slot_pkts_q[hit_slot];
          r.bytes = slot_bytes_q[hit_slot];
        end
      end
    endcase
    return r;
  endfunction

  function automatic word_t noise_word();
    word_t w;
    w.func         = FUNC_FRAME;
    w.device_id    = 4'($urandom);
    w.device_up    = 1'($urandom);
    w.is_loopback  = 1'($urandom);
    w.src_mac      = {16'($urandom), $urandom};
    w.ethertype    = 16'($urandom);
    w.frame_len    = 16'($urandom);
    w.entry_port   = 16'($urandom);
    w.entry_device = 4'($urandom);
    return w;
  endfunction

  function automatic word_t frame_word(input logic [3:0] dev, input logic up, input logic loop,
                                       input logic [47:0] mac, input logic [15:0] et,
                                       input logic [15:0] len);
    word_t w;
    w = noise_word();
    w.func        = FUNC_FRAME;
    w.device_id   = dev;
    w.device_up   = up;
    w.is_loopback = loop;
    w.src_mac     = mac;
    w.ethertype   = et;
    w.frame_len   = len;
    return w;
  endfunction

  function automatic word_t table_word(input func_e f, input logic [15:0] port,
                                       input logic [3:0] dev);
    word_t w;
    w = noise_word();
    w.func         = f;
    w.entry_port   = port;
    w.entry_device = dev;
    return w;
  endfunction

  function automatic word_t random_word();
    word_t w;
    int    live [$];
    int    pick;
    int    s;
    int    i;
    for (i = 0; i < TableEntriesDef; i++) if (slot_valid_q[i]) live.push_back(i);
    w = noise_word();
    w.device_up   = ($urandom_range(99) < 92);
    w.is_loopback = ($urandom_range(99) < 6);
    w.src_mac[40] = ($urandom_range(99) < 5);
    if ($urandom_range(99) < 3) w.src_mac = '0;
    if ($urandom_range(99) < 88) w.ethertype = PortTypeMark | 16'($urandom_range(0, 1023));
    pick = $urandom_range(99);
    if (pick < 60) begin
      if (live.size() != 0 && $urandom_range(99) < 80) begin
        s = live[$urandom_range(0, live.size() - 1)];
        w.device_id = slot_dev_q[s];
        if ($urandom_range(99) < 90) w.ethertype = PortTypeMark | {6'b0, slot_port_q[s]};
      end
    end else if (pick < 75) begin
      w.func = FUNC_ADD;
      if ($urandom_range(99) < 75) w.entry_port = 16'($urandom_range(0, 47));
    end else begin
      w.func = (pick < 87) ? FUNC_REMOVE : FUNC_READ;
      if (live.size() != 0 && $urandom_range(99) < 85)
        w.entry_port = {6'b0, slot_port_q[live[$urandom_range(0, live.size() - 1)]]};
    end
    return w;
  endfunction

  task automatic send_word(input word_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    func_i         <= w.func;
    device_id_i    <= w.device_id;
    device_up_i    <= w.device_up;
    is_loopback_i  <= w.is_loopback;
    src_mac_i      <= w.src_mac;
    ethertype_i    <= w.ethertype;
    frame_len_i    <= w.frame_len;
    entry_port_i   <= w.entry_port;
    entry_device_i <= w.entry_device;
    start          <= 1'b1;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    pending_outcomes.push_back(resolve_word(w));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_hook_mask(input logic [15:0] mask);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HookMaskAddr;
    pwdata  <= {16'h0, mask};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    hook_mask_q = mask;
    // read back
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    if (prdata[15:0] !== mask) begin
      $display("%0t: hook_mask readback mismatch, expected %0h, actual %0h",
               $time, mask, prdata[15:0]);
      errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_table_ops();
    idle_pct = 0;
    send_word(table_word(FUNC_ADD, 16'h0000, 4'd0));
    send_word(table_word(FUNC_ADD, 16'h03FF, 4'd15));
    send_word(table_word(FUNC_ADD, 16'hFC00, 4'd5));
    send_word(table_word(FUNC_REMOVE, 16'hFFFF, 4'd0));
    send_word(table_word(FUNC_READ, 16'h0400, 4'd0));
    drain_results();
  endtask

  task automatic test_frame_checks();
    write_hook_mask(16'hFFFF);
    send_word(frame_word(4'd0, 1'b1, 1'b0, 48'h0200_0000_0001, 16'hAC00, 16'hFFFF));
    send_word(frame_word(4'd15, 1'b1, 1'b0, 48'hFEFF_FFFF_FFFF, 16'hAFFF, 16'h0001));
    send_word(frame_word(4'd0, 1'b1, 1'b0, 48'h0200_0000_0001, 16'hFFFF, 16'h0040));
    send_word(frame_word(4'd0, 1'b0, 1'b0, 48'h0200_0000_0001, 16'hAC00, 16'h0040));
    send_word(frame_word(4'd0, 1'b1, 1'b1, 48'h0200_0000_0001, 16'hAC00, 16'h0040));
    send_word(frame_word(4'd0, 1'b1, 1'b0, 48'h0100_0000_0000, 16'hAC00, 16'h0040));
    send_word(frame_word(4'd0, 1'b1, 1'b0, 48'h0, 16'hAC00, 16'h0040));
    send_word(frame_word(4'd0, 1'b1, 1'b0, 48'h0200_0000_0001, 16'h0800, 16'h0040));
    send_word(frame_word(4'd3, 1'b1, 1'b0, 48'h0200_0000_0001, 16'hAC00, 16'h0040));
    send_word(table_word(FUNC_READ, 16'h0000, 4'd0));
    send_word(table_word(FUNC_READ, 16'h03FF, 4'd0));
    drain_results();
  endtask

  task automatic test_hook_mask();
    write_hook_mask(16'h8000);
    send_word(frame_word(4'd0, 1'b1, 1'b0, 48'h0200_0000_0001, 16'hAC00, 16'h0010));
    send_word(frame_word(4'd15, 1'b1, 1'b0, 48'h0200_0000_0001, 16'hAFFF, 16'h0010));
    drain_results();
    write_hook_mask(16'h0000);
    send_word(frame_word(4'd15, 1'b1, 1'b0, 48'h0200_0000_0001, 16'hAFFF, 16'h0010));
    drain_results();
  endtask

  task automatic test_table_full();
    for (int p = 1; p <= TableEntriesDef - 2; p++)
      send_word(table_word(FUNC_ADD, 16'(p), 4'(p)));
    send_word(table_word(FUNC_ADD, 16'h0200, 4'd7));
    drain_results();
  endtask

  task automatic test_random_traffic(input int count, input int idle, input logic [15:0] mask);
    write_hook_mask(mask);
    idle_pct = idle;
    repeat (count) send_word(random_word());
    drain_results();
  endtask

  task automatic compare_field(input string name, input logic [63:0] exp,
                               input logic [63:0] act);
    if (act !== exp) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    outcome_t exp;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual verdict %0h status %0h",
                 $time, verdict_o, status_o);
        errors++;
      end else begin
        exp = pending_outcomes.pop_front();
        compare_field("verdict", 64'(exp.verdict), 64'(verdict_o));
        compare_field("status", 64'(exp.status), 64'(status_o));
        compare_field("hit_port", 64'(exp.hit_port), 64'(hit_port_o));
        compare_field("packet_count", exp.pkts, packet_count_o);
        compare_field("byte_count", exp.bytes, byte_count_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    start          = 1'b0;
    func_i         = '0;
    device_id_i    = '0;
    device_up_i    = 1'b0;
    is_loopback_i  = 1'b0;
    src_mac_i      = '0;
    ethertype_i    = '0;
    frame_len_i    = '0;
    entry_port_i   = '0;
    entry_device_i = '0;
    errors         = 0;
    idle_pct       = 0;
    hook_mask_q    = '0;
    for (int i = 0; i < TableEntriesDef; i++) begin
      slot_valid_q[i] = 1'b0;
      slot_port_q[i]  = '0;
      slot_dev_q[i]   = '0;
      slot_pkts_q[i]  = '0;
      slot_bytes_q[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_table_ops();
    test_frame_checks();
    test_hook_mask();
    test_table_full();
    test_random_traffic(380, 0, 16'hFFFF);
    test_random_traffic(380, 48, 16'($urandom) | 16'h0001);
    test_random_traffic(380, 13, 16'($urandom) | 16'h8000);

    repeat (2 * TableEntriesDef + 8) @(posedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
